FILE: src/nibble_token_run_decompressor_top_defines.svh
// ----------------------------------------------------------------------------
// Nibble token run decompressor: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_TOKEN_RUN_DECOMPRESSOR_TOP_DEFINES_SVH
`define NIBBLE_TOKEN_RUN_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication
`define NTRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nibtok port check failed");

// next-cycle implication
`define NTRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nibtok port check failed");

`endif

FILE: src/nibtok_pkg.sv
// ----------------------------------------------------------------------------
// nibtok_pkg
// Shared types and codes of the nibble token run decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package nibtok_pkg;

  localparam int SIZE_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // at most one command per input beat; kind KIND_DATA here means no status beat
  typedef struct packed {
    logic [2:0] cnt1;
    logic [7:0] byte1;
    logic [2:0] cnt2;
    logic [7:0] byte2;
    logic [1:0] kind;
  } cmd_t;

endpackage

`default_nettype wire

FILE: src/nibble_token_run_decompressor_top.sv
// Path: a beat's command is registered in the command queue and is then
// loaded into the sequencer before its first result is offered.
// Throughput: one input beat per cycle while the command queue has room;
// results leave one per cycle while out_tready is high (9 per beat max).
// Reset: rst_n synchronous, active low; clears parser, queue and sequencer.
// ----------------------------------------------------------------------------
// nibble_token_run_decompressor_top
// Nibble token run decompressor: parser, command queue, output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_token_run_decompressor_top #(
  parameter int SIZE_BITS   = nibtok_pkg::SIZE_BITS_DEF,
  parameter int QUEUE_DEPTH = nibtok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast
);
  import nibtok_pkg::*;

  logic fire, push, full, pop, empty;
  cmd_t f_cmd, q_cmd;

  assign in_tready = !full;
  assign fire      = in_tvalid && in_tready;

  nibtok_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .cmd     (f_cmd)
  );

  nibtok_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_cmd),
    .full  (full),
    .pop   (pop),
    .dout  (q_cmd),
    .empty (empty)
  );

  nibtok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_cmd     (q_cmd),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: src/nibtok_front.sv
// ----------------------------------------------------------------------------
// nibtok_front
// Parses header, mark and literal bytes and turns each input beat into at
// most one command for the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module nibtok_front #(
  parameter int SIZE_BITS = nibtok_pkg::SIZE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              push,
  output nibtok_pkg::cmd_t  cmd
);
  import nibtok_pkg::*;

  localparam int HDR_BYTES = (SIZE_BITS + 6) / 7;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_MARK   = 2'd1;
  localparam logic [1:0] PH_LIT    = 2'd2;

  typedef struct packed {
    logic                 ok;
    logic [2:0]           cnt;
    logic [7:0]           val;
    logic [2:0]           lit;
    logic [SIZE_BITS-1:0] bl;
  } tok_res_t;

  function automatic tok_res_t tok_eval(input logic [3:0] t,
                                        input logic [SIZE_BITS-1:0] bl);
    tok_res_t   r;
    logic [2:0] n;
    r    = '0;
    r.bl = bl;
    if (t[3]) begin
      n = {1'b0, t[1:0]} + 3'd1;
      if ({{(SIZE_BITS-3){1'b0}}, n} <= bl) begin
        r.ok  = 1'b1;
        r.cnt = n;
        r.val = t[2] ? 8'hFF : 8'h00;
        r.bl  = bl - {{(SIZE_BITS-3){1'b0}}, n};
      end
    end else begin
      n = t[2:0];
      if ({{(SIZE_BITS-3){1'b0}}, n} <= bl) begin
        r.ok  = 1'b1;
        r.lit = n;
      end
    end
    return r;
  endfunction

  logic [1:0]           phase_r, phase_nxt;
  logic [2:0]           hsc_r, hsc_nxt;
  logic [SIZE_BITS-1:0] bl_r, bl_nxt;
  logic [2:0]           ll_r, ll_nxt;
  logic [3:0]           held_r, held_nxt;
  logic                 heldv_r, heldv_nxt;
  logic                 disc_r, disc_nxt;

  logic [5:0]           sft;
  logic [SIZE_BITS+6:0] hdr_w;
  logic [SIZE_BITS-1:0] bl_dec;
  logic [2:0]           ll_dec;
  tok_res_t             ta, tb;
  logic [3:0]           tb_t;
  logic [SIZE_BITS-1:0] tb_bl;

  assign sft    = 6'({3'b000, hsc_r} * 6'd7);
  assign hdr_w  = {{SIZE_BITS{1'b0}}, in_byte[6:0]} << sft;
  assign bl_dec = (bl_r != '0) ? bl_r - {{(SIZE_BITS-1){1'b0}}, 1'b1} : bl_r;
  assign ll_dec = (ll_r != 3'd0) ? ll_r - 3'd1 : ll_r;
  assign ta     = tok_eval(in_byte[3:0], bl_r);
  assign tb_t   = (phase_r == PH_LIT) ? held_r : in_byte[7:4];
  assign tb_bl  = (phase_r == PH_LIT) ? bl_dec : ta.bl;
  assign tb     = tok_eval(tb_t, tb_bl);

  always_comb begin
    phase_nxt = phase_r;
    hsc_nxt   = hsc_r;
    bl_nxt    = bl_r;
    ll_nxt    = ll_r;
    held_nxt  = held_r;
    heldv_nxt = heldv_r;
    disc_nxt  = disc_r;
    cmd       = '0;
    if (!disc_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (sft < 6'd32) begin
            bl_nxt = bl_r | hdr_w[SIZE_BITS-1:0];
          end
          hsc_nxt = hsc_r + 3'd1;
          if (!in_byte[7] || hsc_nxt >= 3'(HDR_BYTES)) begin
            phase_nxt = PH_MARK;
          end
        end
        PH_MARK: begin
          if (ta.ok) begin
            cmd.cnt1  = ta.cnt;
            cmd.byte1 = ta.val;
            bl_nxt    = ta.bl;
            if (ta.lit != 3'd0) begin
              ll_nxt    = ta.lit;
              phase_nxt = PH_LIT;
              held_nxt  = in_byte[7:4];
              heldv_nxt = 1'b1;
            end else if (tb.ok) begin
              cmd.cnt2  = tb.cnt;
              cmd.byte2 = tb.val;
              bl_nxt    = tb.bl;
              if (tb.lit != 3'd0) begin
                ll_nxt    = tb.lit;
                phase_nxt = PH_LIT;
              end
            end else begin
              disc_nxt = 1'b1;
            end
          end else begin
            disc_nxt = 1'b1;
          end
        end
        PH_LIT: begin
          cmd.cnt1  = 3'd1;
          cmd.byte1 = in_byte;
          bl_nxt    = bl_dec;
          ll_nxt    = ll_dec;
          if (ll_dec == 3'd0) begin
            phase_nxt = PH_MARK;
            if (heldv_r) begin
              heldv_nxt = 1'b0;
              if (tb.ok) begin
                cmd.cnt2  = tb.cnt;
                cmd.byte2 = tb.val;
                bl_nxt    = tb.bl;
                if (tb.lit != 3'd0) begin
                  ll_nxt    = tb.lit;
                  phase_nxt = PH_LIT;
                end
              end else begin
                disc_nxt = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (in_last) begin
      cmd.kind  = (disc_nxt || phase_nxt != PH_MARK || bl_nxt != '0) ? KIND_ERR : KIND_OK;
      phase_nxt = PH_HEADER;
      hsc_nxt   = 3'd0;
      bl_nxt    = '0;
      ll_nxt    = 3'd0;
      held_nxt  = 4'd0;
      heldv_nxt = 1'b0;
      disc_nxt  = 1'b0;
    end
  end

  assign push = fire && (cmd.cnt1 != 3'd0 || cmd.cnt2 != 3'd0 || cmd.kind != KIND_DATA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hsc_r   <= 3'd0;
      bl_r    <= '0;
      ll_r    <= 3'd0;
      held_r  <= 4'd0;
      heldv_r <= 1'b0;
      disc_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hsc_r   <= hsc_nxt;
      bl_r    <= bl_nxt;
      ll_r    <= ll_nxt;
      held_r  <= held_nxt;
      heldv_r <= heldv_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/nibtok_fifo.sv
// ----------------------------------------------------------------------------
// nibtok_fifo
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module nibtok_fifo #(
  parameter int DEPTH = nibtok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nibtok_pkg::cmd_t  din,
  output logic              full,
  input  logic              pop,
  output nibtok_pkg::cmd_t  dout,
  output logic              empty
);
  import nibtok_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/nibtok_back.sv
// ----------------------------------------------------------------------------
// nibtok_back
// Expands queued commands into result beats, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module nibtok_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  nibtok_pkg::cmd_t  q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_last
);
  import nibtok_pkg::*;

  logic       busy_r, busy_nxt;
  logic [2:0] c1_r, c1_nxt;
  logic [2:0] c2_r, c2_nxt;
  logic       st_r, st_nxt;
  logic [7:0] b1_r, b1_nxt;
  logic [7:0] b2_r, b2_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [3:0] left;
  logic       take, need_load;

  assign left      = {1'b0, c1_r} + {1'b0, c2_r} + {3'b000, st_r};
  assign out_valid = busy_r;
  assign out_last  = (left == 4'd1);
  assign take      = busy_r && out_ready;
  assign need_load = !busy_r || (take && out_last);
  assign q_pop     = need_load && !q_empty;

  always_comb begin
    priority if (c1_r != 3'd0) begin
      out_byte = b1_r;
      out_kind = KIND_DATA;
    end else if (c2_r != 3'd0) begin
      out_byte = b2_r;
      out_kind = KIND_DATA;
    end else begin
      out_byte = 8'h00;
      out_kind = kind_r;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    c1_nxt   = c1_r;
    c2_nxt   = c2_r;
    st_nxt   = st_r;
    b1_nxt   = b1_r;
    b2_nxt   = b2_r;
    kind_nxt = kind_r;
    if (need_load) begin
      busy_nxt = !q_empty;
      c1_nxt   = q_cmd.cnt1;
      c2_nxt   = q_cmd.cnt2;
      st_nxt   = (q_cmd.kind != KIND_DATA);
      b1_nxt   = q_cmd.byte1;
      b2_nxt   = q_cmd.byte2;
      kind_nxt = q_cmd.kind;
    end else if (take) begin
      priority if (c1_r != 3'd0) begin
        c1_nxt = c1_r - 3'd1;
      end else if (c2_r != 3'd0) begin
        c2_nxt = c2_r - 3'd1;
      end else begin
        st_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      c1_r   <= 3'd0;
      c2_r   <= 3'd0;
      st_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_r   <= b1_nxt;
    b2_r   <= b2_nxt;
    kind_r <= kind_nxt;
  end

endmodule

`default_nettype wire

FILE: src/nibtok_checker.sv
// ----------------------------------------------------------------------------
// nibtok_checker
// Port-level checks of the decompressor output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nibble_token_run_decompressor_top_defines.svh"

module nibtok_checker (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_tready,
  input  wire       out_tvalid,
  input  wire       out_tready,
  input  wire [7:0] out_tdata,
  input  wire [1:0] out_tuser,
  input  wire       out_tlast
);
  import nibtok_pkg::*;

  // a status beat closes the results of its input beat
  `NTRD_ASSERT_IMP(a_status_last, out_tvalid && out_tuser != KIND_DATA, out_tlast)

  // a status beat carries a zero byte
  `NTRD_ASSERT_IMP(a_status_zero, out_tvalid && out_tuser != KIND_DATA, out_tdata == 8'h00)

  // stalled beat holds
  `NTRD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // a full queue means the sequencer is presenting a beat
  `NTRD_ASSERT_IMP(a_full_busy, !in_tready, out_tvalid)

endmodule

bind nibble_token_run_decompressor_top nibtok_checker u_nibtok_checker (.*);

`default_nettype wire
